// File: design/c8ex_pkg.sv
// Package for the CHIP-8 instruction execute unit.
// Holds command codes, fault codes and machine constants; no dependencies.
package c8ex_pkg;

  localparam logic [1:0] CmdLoad = 2'd0;
  localparam logic [1:0] CmdExec = 2'd1;
  localparam logic [1:0] CmdTick = 2'd2;

  localparam logic [1:0] FaultNone      = 2'd0;
  localparam logic [1:0] FaultOverflow  = 2'd1;
  localparam logic [1:0] FaultUnderflow = 2'd2;

  localparam logic [15:0] PcReset  = 16'h0200;
  localparam logic [15:0] FontBase = 16'h0050;

endpackage

// File: design/chip8_instruction_execute_unit.sv
// Top level of the CHIP-8 instruction execute unit.
// Depends on c8ex_pkg; holds main memory, return stack and all machine state.
//
// Channel | Dir | Signals                      | Content
// s_axis  | in  | tvalid tready tdata(64 bits) | cmd, instruction, mem_address, mem_data,
//         |     |                              | keys_held, random_byte
// m_axis  | out | tvalid tready tdata(72 bits) | PC, index, draw info, timers, fault, wait
//
// A load, tick or simple instruction passes through the accept, execute and result states.
// Fx55 writes one byte per cycle through the single memory write port; Fx65 alternates
// a read and a write state for each byte, as each byte waits out the registered memory read.
// Main memory is cleared after reset; no item is accepted meanwhile.
// A new item is accepted only after the previous result has been taken.
module chip8_instruction_execute_unit
  import c8ex_pkg::*;
#(
  parameter int STACK_DEPTH  = 16,
  parameter int MEMORY_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] cmd, [17:2] instruction, [29:18] mem_address, [37:30] mem_data,
  // [53:38] keys_held, [61:54] random_byte, [63:62] zero
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] program_counter, [31:16] index_value, [32] draw_request, [40:33] draw_x,
  // [48:41] draw_y, [53:49] draw_rows, [54] clear_screen, [55] sound_active,
  // [63:56] delay_value, [65:64] fault, [66] waiting_key, [71:67] zero
  output logic [71:0] m_axis_tdata
);

  localparam int AW = $clog2(MEMORY_BYTES);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int PW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    StClear, StIdle, StExec, StStore, StLoadRd, StLoadWr, StOut
  } state_e;

  state_e state_q;
  logic [AW-1:0] clr_q;

  // Machine state
  logic [7:0]  v_q [16];
  logic [15:0] i_q, pc_q;
  logic [PW-1:0] sp_q;
  logic [7:0]  dt_q, st_q;
  logic [15:0] stack_mem [STACK_DEPTH];
  logic [7:0]  mem [MEMORY_BYTES];

  // Latched item
  logic [1:0]  cmd_q;
  logic [15:0] op_q, keys_q;
  logic [AW-1:0] addr_q;
  logic [7:0]  data_q, rnd_q;
  logic [3:0]  j_q;

  // Result fields
  logic        draw_q, clr_scr_q, wait_q;
  logic [7:0]  dx_q, dy_q;
  logic [4:0]  rows_q;
  logic [1:0]  fault_q;

  // Memory port and registered read data
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [7:0]    mem_wd, mem_rd_q;
  logic [15:0]   stk_rd_q;

  // Opcode fields
  logic [3:0]  ox, oy, on;
  logic [7:0]  kk, vx, vy;
  logic [15:0] pc2;
  logic [8:0]  sum9;
  logic        pressed;
  logic [3:0]  key_lo;
  logic [AW-1:0] ij_addr;

  assign ox  = op_q[11:8];
  assign oy  = op_q[7:4];
  assign on  = op_q[3:0];
  assign kk  = op_q[7:0];
  assign vx  = v_q[ox];
  assign vy  = v_q[oy];
  assign pc2 = pc_q + 16'd2;
  assign sum9 = {1'b0, vx} + {1'b0, vy};
  assign pressed = (vx < 8'd16) && keys_q[vx[3:0]];
  assign ij_addr = AW'(i_q + {12'd0, j_q});

  // Lowest held key
  always_comb begin
    key_lo = 4'd0;
    for (int k = 15; k >= 0; k--) begin
      if (keys_q[k]) key_lo = 4'(k);
    end
  end

  // Memory port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_q;
    mem_wd = data_q;
    mem_ra = ij_addr;
    if (state_q == StClear) begin
      mem_we = 1'b1;
      mem_wa = clr_q;
      mem_wd = 8'd0;
    end else if (state_q == StExec && cmd_q == CmdLoad) begin
      mem_we = 1'b1;
    end else if (state_q == StStore) begin
      mem_we = 1'b1;
      mem_wa = ij_addr;
      mem_wd = v_q[j_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd_q <= mem[mem_ra];
  end

  // Stack read of the top entry, registered at accept time; a call (2nnn) pushes the return address
  always_ff @(posedge clk_i) begin
    stk_rd_q <= stack_mem[SW'(sp_q - PW'(1))];
    if (state_q == StExec && cmd_q == CmdExec && op_q[15:12] == 4'h2 &&
        sp_q < PW'(STACK_DEPTH)) begin
      stack_mem[SW'(sp_q)] <= pc2;
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata = {5'd0, wait_q, fault_q, dt_q, (st_q != 8'd0), clr_scr_q,
                         rows_q, dy_q, dx_q, draw_q, i_q, pc_q};

  // Sequencer and machine state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
      for (int r = 0; r < 16; r++) v_q[r] <= 8'd0;
      i_q  <= 16'd0;
      pc_q <= PcReset;
      sp_q <= '0;
      dt_q <= 8'd0;
      st_q <= 8'd0;
    end else begin
      unique case (state_q)
        StClear: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(MEMORY_BYTES - 1)) state_q <= StIdle;
        end
        StIdle: begin
          if (s_axis_tvalid) begin
            cmd_q  <= s_axis_tdata[1:0];
            op_q   <= s_axis_tdata[17:2];
            addr_q <= AW'(s_axis_tdata[29:18]);
            data_q <= s_axis_tdata[37:30];
            keys_q <= s_axis_tdata[53:38];
            rnd_q  <= s_axis_tdata[61:54];
            state_q <= StExec;
          end
        end
        StExec: begin
          draw_q <= 1'b0; dx_q <= 8'd0; dy_q <= 8'd0; rows_q <= 5'd0;
          clr_scr_q <= 1'b0; wait_q <= 1'b0; fault_q <= FaultNone;
          j_q <= 4'd0;
          state_q <= StOut;
          case (cmd_q)
            CmdTick: begin
              if (dt_q != 8'd0) dt_q <= dt_q - 8'd1;
              if (st_q != 8'd0) st_q <= st_q - 8'd1;
            end
            CmdExec: begin
              pc_q <= pc2;
              case (op_q[15:12])
                4'h0: begin
                  if (op_q == 16'h00E0) clr_scr_q <= 1'b1;
                  else if (op_q == 16'h00EE) begin
                    if (sp_q == '0) fault_q <= FaultUnderflow;
                    else begin
                      sp_q <= sp_q - PW'(1);
                      pc_q <= stk_rd_q;
                    end
                  end
                end
                4'h1: pc_q <= {4'd0, op_q[11:0]};
                4'h2: begin
                  if (sp_q >= PW'(STACK_DEPTH)) fault_q <= FaultOverflow;
                  else begin
                    sp_q <= sp_q + PW'(1);
                    pc_q <= {4'd0, op_q[11:0]};
                  end
                end
                4'h3: if (vx == kk) pc_q <= pc_q + 16'd4;
                4'h4: if (vx != kk) pc_q <= pc_q + 16'd4;
                4'h5: if (on == 4'd0 && vx == vy) pc_q <= pc_q + 16'd4;
                4'h6: v_q[ox] <= kk;
                4'h7: v_q[ox] <= vx + kk;
                4'h8: begin
                  case (on)
                    4'h0: v_q[ox] <= vy;
                    4'h1: v_q[ox] <= vx | vy;
                    4'h2: v_q[ox] <= vx & vy;
                    4'h3: v_q[ox] <= vx ^ vy;
                    4'h4: begin
                      v_q[ox] <= sum9[7:0];
                      v_q[15] <= {7'd0, sum9[8]};
                    end
                    4'h5: begin
                      v_q[ox] <= vx - vy;
                      v_q[15] <= {7'd0, vx >= vy};
                    end
                    4'h6: begin
                      v_q[ox] <= {1'b0, vx[7:1]};
                      v_q[15] <= {7'd0, vx[0]};
                    end
                    4'h7: begin
                      v_q[ox] <= vy - vx;
                      v_q[15] <= {7'd0, vy >= vx};
                    end
                    4'hE: begin
                      v_q[ox] <= {vx[6:0], 1'b0};
                      v_q[15] <= {7'd0, vx[7]};
                    end
                    default: ;
                  endcase
                end
                4'h9: if (on == 4'd0 && vx != vy) pc_q <= pc_q + 16'd4;
                4'hA: i_q <= {4'd0, op_q[11:0]};
                4'hB: pc_q <= {8'd0, v_q[0]} + {4'd0, op_q[11:0]};
                4'hC: v_q[ox] <= ((rnd_q == 8'hFF) ? 8'd0 : rnd_q) & kk;
                4'hD: begin
                  draw_q <= 1'b1; dx_q <= vx; dy_q <= vy;
                  rows_q <= {1'b0, on} + 5'd1;
                end
                4'hE: begin
                  if (kk == 8'h9E && pressed) pc_q <= pc_q + 16'd4;
                  if (kk == 8'hA1 && !pressed) pc_q <= pc_q + 16'd4;
                end
                4'hF: begin
                  case (kk)
                    8'h07: v_q[ox] <= dt_q;
                    8'h0A: begin
                      if (keys_q == 16'd0) begin
                        wait_q <= 1'b1;
                        pc_q <= pc_q;
                      end else v_q[ox] <= {4'd0, key_lo};
                    end
                    8'h15: dt_q <= vx;
                    8'h18: st_q <= vx;
                    8'h1E: i_q <= i_q + {8'd0, vx};
                    8'h29: i_q <= FontBase + ({8'd0, vx} << 2) + {8'd0, vx};
                    8'h55: state_q <= StStore;
                    8'h65: state_q <= StLoadRd;
                    default: ;
                  endcase
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
        StStore: begin
          j_q <= j_q + 4'd1;
          if (j_q == ox) state_q <= StOut;
        end
        StLoadRd: state_q <= StLoadWr;
        StLoadWr: begin
          v_q[j_q] <= mem_rd_q;
          j_q <= j_q + 4'd1;
          state_q <= (j_q == ox) ? StOut : StLoadRd;
        end
        StOut: if (m_axis_tready) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
